// File: hw/rtl/iacr_pkg.sv
package iacr_pkg;

   localparam int SETTLE_BITS_DEF = 16;

   localparam logic [1:0] REG_DEVICE_ADDRESS  = 2'd0;
   localparam logic [1:0] REG_GAIN_MODE_BITS  = 2'd1;
   localparam logic [1:0] REG_CONFIG_LOW_BYTE = 2'd2;
   localparam logic [1:0] REG_SETTLE_TICKS    = 2'd3;

   localparam logic [6:0]  DEVICE_ADDRESS_RST  = 7'd72;
   localparam logic [3:0]  GAIN_MODE_BITS_RST  = 4'd0;
   localparam logic [7:0]  CONFIG_LOW_BYTE_RST = 8'hE3;
   localparam logic [15:0] SETTLE_TICKS_RST    = 16'd250;

   localparam logic [7:0] PTR_CONFIG     = 8'h01;
   localparam logic [7:0] PTR_CONVERSION = 8'h00;
   localparam logic [7:0] CFG_HIGH_BASE  = 8'hC0;

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_CFG_START = 13'b0000000000010,
      ST_CFG_WRITE = 13'b0000000000100,
      ST_CFG_STOP  = 13'b0000000001000,
      ST_WAIT1     = 13'b0000000010000,
      ST_PTR_START = 13'b0000000100000,
      ST_PTR_WRITE = 13'b0000001000000,
      ST_PTR_STOP  = 13'b0000010000000,
      ST_WAIT2     = 13'b0000100000000,
      ST_RD_START  = 13'b0001000000000,
      ST_RD_ADDR   = 13'b0010000000000,
      ST_RD_READ   = 13'b0100000000000,
      ST_RD_STOP   = 13'b1000000000000
   } stage_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [3:0]  gain_mode_bits;
      logic [7:0]  config_low_byte;
      logic [15:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic       sda_sample;
      logic [1:0] channel;
      logic       start_request;
   } req_type;

   typedef struct packed {
      logic        nack_seen;
      logic [15:0] magnitude;
      logic        done_pulse;
      logic        busy_res;
      logic        sda_release;
      logic        scl_level;
   } rsp_type;

endpackage

// File: hw/rtl/iacr_seq.sv
module iacr_seq #(
   parameter int SETTLE_BITS = iacr_pkg::SETTLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  iacr_pkg::req_type req,
   input  iacr_pkg::cfg_type cfg,
   output iacr_pkg::rsp_type res
);
   import iacr_pkg::*;

   stage_type              stage_ff, stage_in;
   logic [1:0]             q_ff, q_in;
   logic [3:0]             bit_ff, bit_in;
   logic [1:0]             byte_ff, byte_in;
   logic [7:0]             shift_ff, shift_in;
   logic [7:0]             high_ff, high_in;
   logic [SETTLE_BITS-1:0] wait_ff, wait_in;
   logic [1:0]             chan_ff, chan_in;
   logic [15:0]            result_ff, result_in;
   logic                   nack_ff, nack_in;

   stage_type              stage_cur, work;
   logic [1:0]             q_eff;
   logic                   last_q;
   logic                   scl, sda, done;
   logic [7:0]             addr_w, tx_byte;
   logic [2:0]             bytes_in, byte_sum;
   logic [SETTLE_BITS-1:0] limit, wc_next;
   logic [15:0]            code;

   assign limit = SETTLE_BITS'({16'd0, cfg.settle_ticks});
   assign addr_w = {cfg.device_address, 1'b0};

   always_comb begin
      unique case (stage_ff)
         ST_CFG_START, ST_CFG_WRITE, ST_CFG_STOP, ST_WAIT1,
         ST_PTR_START, ST_PTR_WRITE, ST_PTR_STOP, ST_WAIT2,
         ST_RD_START, ST_RD_ADDR, ST_RD_READ, ST_RD_STOP: stage_cur = stage_ff;
         default: stage_cur = ST_IDLE;
      endcase

      if (stage_ff == ST_CFG_WRITE) begin
         case (byte_ff)
            2'd0:    tx_byte = addr_w;
            2'd1:    tx_byte = PTR_CONFIG;
            2'd2:    tx_byte = CFG_HIGH_BASE | {2'b00, chan_ff, cfg.gain_mode_bits};
            default: tx_byte = cfg.config_low_byte;
         endcase
         bytes_in = 3'd4;
      end else if (stage_ff == ST_PTR_WRITE) begin
         tx_byte  = (byte_ff == 2'd0) ? addr_w : PTR_CONVERSION;
         bytes_in = 3'd2;
      end else begin
         tx_byte  = addr_w | 8'h01;
         bytes_in = 3'd1;
      end

      stage_in  = stage_cur;
      q_eff     = q_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      high_in   = high_ff;
      wait_in   = wait_ff;
      chan_in   = chan_ff;
      result_in = result_ff;
      nack_in   = nack_ff;
      scl       = 1'b1;
      sda       = 1'b1;
      done      = 1'b0;
      byte_sum  = {1'b0, byte_ff} + 3'd1;
      wc_next   = wait_ff + SETTLE_BITS'(1);
      code      = {high_ff, shift_ff};

      if (stage_cur == ST_IDLE && req.start_request) begin
         chan_in  = req.channel;
         nack_in  = 1'b0;
         q_eff    = 2'd0;
         bit_in   = 4'd0;
         byte_in  = 2'd0;
         stage_in = ST_CFG_START;
      end
      work   = stage_in;
      last_q = (q_eff == 2'd3);

      unique case (work)
         ST_CFG_START, ST_PTR_START, ST_RD_START: begin
            scl = (q_eff != 2'd3);
            sda = !q_eff[1];
            if (last_q) begin
               stage_in = stage_type'(work << 1);
               bit_in   = 4'd0;
               byte_in  = 2'd0;
            end
         end
         ST_CFG_WRITE, ST_PTR_WRITE, ST_RD_ADDR: begin
            scl = q_eff[1];
            if (!bit_ff[3]) begin
               sda = tx_byte[3'd7 - bit_ff[2:0]];
            end else begin
               sda = 1'b1;
               if (last_q && req.sda_sample) begin
                  nack_in = 1'b1;
               end
            end
            if (last_q) begin
               if (!bit_ff[3]) begin
                  bit_in = bit_ff + 4'd1;
               end else begin
                  bit_in = 4'd0;
                  if (byte_sum >= bytes_in) begin
                     byte_in  = 2'd0;
                     stage_in = stage_type'(work << 1);
                  end else begin
                     byte_in = byte_sum[1:0];
                  end
               end
            end
         end
         ST_RD_READ: begin
            scl = q_eff[1];
            if (!bit_ff[3]) begin
               sda = 1'b1;
               if (last_q) begin
                  shift_in = {shift_ff[6:0], req.sda_sample};
               end
            end else begin
               sda = (byte_ff != 2'd0);
            end
            if (last_q) begin
               if (!bit_ff[3]) begin
                  bit_in = bit_ff + 4'd1;
               end else begin
                  bit_in = 4'd0;
                  if (byte_ff == 2'd0) begin
                     high_in = shift_ff;
                     byte_in = 2'd1;
                  end else begin
                     byte_in  = 2'd0;
                     stage_in = ST_RD_STOP;
                  end
               end
            end
         end
         ST_CFG_STOP, ST_PTR_STOP, ST_RD_STOP: begin
            scl = (q_eff != 2'd0);
            sda = q_eff[1];
            if (last_q) begin
               wait_in = '0;
               if (work == ST_CFG_STOP) begin
                  stage_in = (limit == '0) ? ST_PTR_START : ST_WAIT1;
               end else if (work == ST_PTR_STOP) begin
                  stage_in = (limit == '0) ? ST_RD_START : ST_WAIT2;
               end else begin
                  result_in = code[15] ? (~code + 16'd1) : code;
                  done      = 1'b1;
                  stage_in  = ST_IDLE;
               end
            end
         end
         ST_WAIT1, ST_WAIT2: begin
            wait_in = wc_next;
            if (wc_next >= limit || wc_next == '0) begin
               wait_in  = '0;
               stage_in = stage_type'(work << 1);
            end
         end
         default: begin
         end
      endcase

      if (stage_in != ST_IDLE && stage_in != ST_WAIT1 && stage_in != ST_WAIT2) begin
         q_in = q_eff + 2'd1;
      end else begin
         q_in = 2'd0;
      end

      res.scl_level   = scl;
      res.sda_release = sda;
      res.busy_res    = (stage_in != ST_IDLE);
      res.done_pulse  = done;
      res.magnitude   = result_in;
      res.nack_seen   = nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= ST_IDLE;
         q_ff      <= '0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         shift_ff  <= '0;
         high_ff   <= '0;
         wait_ff   <= '0;
         chan_ff   <= '0;
         result_ff <= '0;
         nack_ff   <= 1'b0;
      end else if (accept) begin
         stage_ff  <= stage_in;
         q_ff      <= q_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         high_ff   <= high_in;
         wait_ff   <= wait_in;
         chan_ff   <= chan_in;
         result_ff <= result_in;
         nack_ff   <= nack_in;
      end
   end

endmodule

// File: hw/rtl/i2c_adc_channel_reader_core.sv
// Result: each accepted tick is registered and its result is offered in the next cycle.
// Throughput: one tick per cycle while no result is stalled; the sequencer state advances
// on every accepted tick and the result register frees as soon as its transfer completes.
// Reset (synchronous, active high): sequencer idle, counters and result cleared,
// registers at their defaults (address 72, gain 0, low byte 0xE3, settle 250).
module i2c_adc_channel_reader_core #(
   parameter int SETTLE_BITS = iacr_pkg::SETTLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // start_request, channel[1:0], sda_sample, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // scl_level, sda_release, busy_res, done_pulse,
                                    // magnitude[15:0], nack_seen, pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import iacr_pkg::*;

   cfg_type cfg_ff;
   logic    csr_wr;
   logic    accept;
   req_type req;
   rsp_type res;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address  <= DEVICE_ADDRESS_RST;
         cfg_ff.gain_mode_bits  <= GAIN_MODE_BITS_RST;
         cfg_ff.config_low_byte <= CONFIG_LOW_BYTE_RST;
         cfg_ff.settle_ticks    <= SETTLE_TICKS_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_DEVICE_ADDRESS:  cfg_ff.device_address  <= csr_pwdata[6:0];
            REG_GAIN_MODE_BITS:  cfg_ff.gain_mode_bits  <= csr_pwdata[3:0];
            REG_CONFIG_LOW_BYTE: cfg_ff.config_low_byte <= csr_pwdata[7:0];
            REG_SETTLE_TICKS:    cfg_ff.settle_ticks    <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DEVICE_ADDRESS:  csr_prdata = {25'd0, cfg_ff.device_address};
         REG_GAIN_MODE_BITS:  csr_prdata = {28'd0, cfg_ff.gain_mode_bits};
         REG_CONFIG_LOW_BYTE: csr_prdata = {24'd0, cfg_ff.config_low_byte};
         REG_SETTLE_TICKS:    csr_prdata = {16'd0, cfg_ff.settle_ticks};
         default:             csr_prdata = '0;
      endcase
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign req        = req_type'(req_tdata[3:0]);

   iacr_seq #(
      .SETTLE_BITS(SETTLE_BITS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req),
      .cfg   (cfg_ff),
      .res   (res)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_pulse) |-> !rsp_data_ff.busy_res)
      else $error("completion flagged while still busy");

endmodule

// File: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import iacr_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_TICKS  = 300;
   localparam int PRINT_LIMIT   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   i2c_adc_channel_reader_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bus master model state
   cfg_type     bus_cfg;
   stage_type   bus_stage;
   logic [1:0]  bus_quarter;
   logic [3:0]  bit_pos;
   logic [1:0]  byte_pos;
   logic [7:0]  rx_shift;
   logic [7:0]  rx_high;
   logic [SETTLE_BITS_DEF-1:0] settle_count;
   logic [1:0]  latched_channel;
   logic [15:0] magnitude_hold;
   logic        ack_missing;

   rsp_type     bus_outputs_due[$];
   int          fail_count = 0;
   int          ticks_sent = 0;
   bit          idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic stage_type next_of(stage_type s);
      return stage_type'(s << 1);
   endfunction

   function automatic logic [7:0] tx_byte();
      logic [7:0] addr_w;
      addr_w = {bus_cfg.device_address, 1'b0};
      if (bus_stage == ST_CFG_WRITE) begin
         case (byte_pos)
            2'd0: return addr_w;
            2'd1: return PTR_CONFIG;
            2'd2: return CFG_HIGH_BASE | {2'b00, latched_channel, 4'b0000}
                         | {4'b0000, bus_cfg.gain_mode_bits};
            default: return bus_cfg.config_low_byte;
         endcase
      end
      if (bus_stage == ST_PTR_WRITE)
         return (byte_pos == 2'd0) ? addr_w : PTR_CONVERSION;
      return addr_w | 8'h01;
   endfunction

   function automatic logic [1:0] last_byte_of_stage();
      if (bus_stage == ST_CFG_WRITE) return 2'd3;
      if (bus_stage == ST_PTR_WRITE) return 2'd1;
      return 2'd0;
   endfunction

   function automatic rsp_type advance_i2c_master(req_type t);
      rsp_type     r;
      logic        scl;
      logic        sda;
      logic        done;
      logic [1:0]  q;
      logic        last_q;
      logic [15:0] code;
      logic [7:0]  tx;
      scl = 1'b1;
      sda = 1'b1;
      done = 1'b0;
      q = bus_quarter;
      last_q = (q == 2'd3);
      if (bus_stage == ST_IDLE && t.start_request) begin
         latched_channel = t.channel;
         ack_missing = 1'b0;
         bus_quarter = 2'd0;
         bit_pos = '0;
         byte_pos = '0;
         q = 2'd0;
         last_q = 1'b0;
         bus_stage = ST_CFG_START;
      end
      case (bus_stage)
         ST_CFG_START, ST_PTR_START, ST_RD_START: begin
            scl = (q < 2'd3);
            sda = (q < 2'd2);
            if (last_q) begin
               bus_stage = next_of(bus_stage);
               bit_pos = '0;
               byte_pos = '0;
            end
         end
         ST_CFG_WRITE, ST_PTR_WRITE, ST_RD_ADDR: begin
            scl = (q >= 2'd2);
            if (bit_pos < 4'd8) begin
               tx = tx_byte();
               sda = tx[7 - bit_pos];
            end else if (last_q && t.sda_sample) begin
               ack_missing = 1'b1;
            end
            if (last_q) begin
               if (bit_pos < 4'd8) begin
                  bit_pos = bit_pos + 4'd1;
               end else begin
                  bit_pos = '0;
                  if (byte_pos == last_byte_of_stage()) begin
                     byte_pos = '0;
                     bus_stage = next_of(bus_stage);
                  end else begin
                     byte_pos = byte_pos + 2'd1;
                  end
               end
            end
         end
         ST_RD_READ: begin
            scl = (q >= 2'd2);
            if (bit_pos < 4'd8) begin
               if (last_q) rx_shift = {rx_shift[6:0], t.sda_sample};
            end else begin
               sda = (byte_pos != 2'd0);
            end
            if (last_q) begin
               if (bit_pos < 4'd8) begin
                  bit_pos = bit_pos + 4'd1;
               end else begin
                  bit_pos = '0;
                  if (byte_pos == 2'd0) begin
                     rx_high = rx_shift;
                     byte_pos = 2'd1;
                  end else begin
                     byte_pos = '0;
                     bus_stage = ST_RD_STOP;
                  end
               end
            end
         end
         ST_CFG_STOP, ST_PTR_STOP, ST_RD_STOP: begin
            scl = (q >= 2'd1);
            sda = (q >= 2'd2);
            if (last_q) begin
               settle_count = '0;
               if (bus_stage == ST_CFG_STOP) begin
                  bus_stage = (bus_cfg.settle_ticks == 0) ? ST_PTR_START : ST_WAIT1;
               end else if (bus_stage == ST_PTR_STOP) begin
                  bus_stage = (bus_cfg.settle_ticks == 0) ? ST_RD_START : ST_WAIT2;
               end else begin
                  code = {rx_high, rx_shift};
                  magnitude_hold = code[15] ? (16'd0 - code) : code;
                  done = 1'b1;
                  bus_stage = ST_IDLE;
               end
            end
         end
         ST_WAIT1, ST_WAIT2: begin
            settle_count = settle_count + 1'b1;
            if (settle_count >= bus_cfg.settle_ticks[SETTLE_BITS_DEF-1:0]
                || settle_count == 0) begin
               settle_count = '0;
               bus_stage = next_of(bus_stage);
            end
         end
         default: ;
      endcase
      if (bus_stage != ST_IDLE && bus_stage != ST_WAIT1 && bus_stage != ST_WAIT2)
         bus_quarter = q + 2'd1;
      else
         bus_quarter = 2'd0;
      r.scl_level   = scl;
      r.sda_release = sda;
      r.busy_res    = (bus_stage != ST_IDLE);
      r.done_pulse  = done;
      r.magnitude   = magnitude_hold;
      r.nack_seen   = ack_missing;
      return r;
   endfunction

   // slave side: ACK slots driven low unless a miss is drawn, read bits from code
   function automatic logic slave_sda(logic [15:0] code, int unsigned miss_pct);
      if ((bus_stage == ST_CFG_WRITE || bus_stage == ST_PTR_WRITE || bus_stage == ST_RD_ADDR)
          && bit_pos == 4'd8)
         return ($urandom_range(0, 99) < miss_pct);
      if (bus_stage == ST_RD_READ && bit_pos < 4'd8)
         return (byte_pos == 2'd0) ? code[15 - bit_pos] : code[7 - bit_pos];
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
         REG_DEVICE_ADDRESS:  return {25'd0, bus_cfg.device_address};
         REG_GAIN_MODE_BITS:  return {28'd0, bus_cfg.gain_mode_bits};
         REG_CONFIG_LOW_BYTE: return {24'd0, bus_cfg.config_low_byte};
         default:             return {16'd0, bus_cfg.settle_ticks};
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic send_tick(req_type t);
      if (idle_on && $urandom_range(0, 15) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
      bus_outputs_due.push_back(advance_i2c_master(t));
   endtask

   task automatic send_noise(int n);
      req_type t;
      repeat (n) begin
         t.start_request = 1'b0;
         t.channel = 2'($urandom_range(0, 3));
         t.sda_sample = 1'($urandom_range(0, 1));
         send_tick(t);
      end
   endtask

   // start request while busy is drawn at random on every tick of the sequence
   task automatic run_conversion(logic [1:0] ch, logic [15:0] code, int unsigned miss_pct);
      req_type t;
      t.start_request = 1'b1;
      t.channel = ch;
      t.sda_sample = 1'($urandom_range(0, 1));
      send_tick(t);
      while (bus_stage != ST_IDLE) begin
         t.start_request = 1'($urandom_range(0, 1));
         t.channel = 2'($urandom_range(0, 3));
         t.sda_sample = slave_sda(code, miss_pct);
         send_tick(t);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bus_outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_DEVICE_ADDRESS:  bus_cfg.device_address = value[6:0];
         REG_GAIN_MODE_BITS:  bus_cfg.gain_mode_bits = value[3:0];
         REG_CONFIG_LOW_BYTE: bus_cfg.config_low_byte = value[7:0];
         default:             bus_cfg.settle_ticks = value[15:0];
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(logic [1:0] idx);
      logic [31:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== reg_value(idx)) report_mismatch("csr readback", got, reg_value(idx));
      @(posedge clock);
   endtask

   task automatic set_config(logic [31:0] addr, logic [31:0] gain, logic [31:0] low,
                             logic [31:0] settle);
      drain();
      csr_write(REG_DEVICE_ADDRESS, addr);
      csr_write(REG_GAIN_MODE_BITS, gain);
      csr_write(REG_CONFIG_LOW_BYTE, low);
      csr_write(REG_SETTLE_TICKS, settle);
      csr_check(REG_DEVICE_ADDRESS);
      csr_check(REG_GAIN_MODE_BITS);
      csr_check(REG_CONFIG_LOW_BYTE);
      csr_check(REG_SETTLE_TICKS);
   endtask

   // result checker
   initial begin
      rsp_type got;
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[20:0]);
            if (bus_outputs_due.size() == 0) begin
               report_mismatch("unexpected transfer", 32'(rsp_tdata), 0);
            end else begin
               want = bus_outputs_due.pop_front();
               if (got.scl_level !== want.scl_level)
                  report_mismatch("scl_level", 32'(got.scl_level), 32'(want.scl_level));
               if (got.sda_release !== want.sda_release)
                  report_mismatch("sda_release", 32'(got.sda_release),
                                  32'(want.sda_release));
               if (got.busy_res !== want.busy_res)
                  report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
               if (got.done_pulse !== want.done_pulse)
                  report_mismatch("done_pulse", 32'(got.done_pulse), 32'(want.done_pulse));
               if (got.magnitude !== want.magnitude)
                  report_mismatch("magnitude", 32'(got.magnitude), 32'(want.magnitude));
               if (got.nack_seen !== want.nack_seen)
                  report_mismatch("nack_seen", 32'(got.nack_seen), 32'(want.nack_seen));
            end
         end
      end
   end

   // result-side backpressure
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 11) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic test_reset_state();
      csr_check(REG_DEVICE_ADDRESS);
      csr_check(REG_GAIN_MODE_BITS);
      csr_check(REG_CONFIG_LOW_BYTE);
      csr_check(REG_SETTLE_TICKS);
      send_noise(16);
   endtask

   // all-ones config, zero settle, every ACK missing, negative full scale
   task automatic test_missing_ack();
      set_config(127, 15, 255, 0);
      run_conversion(2'd3, 16'h8000, 100);
   endtask

   task automatic test_random_traffic();
      int          first;
      logic [15:0] code;
      logic [31:0] settle;
      first = ticks_sent;
      while (ticks_sent - first < RANDOM_TICKS) begin
         if ($urandom_range(0, 1) == 0) begin
            settle = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) settle = settle | ($urandom() & 32'hFFFF0000);
            set_config($urandom(), $urandom(), $urandom(), settle);
         end
         send_noise($urandom_range(0, 5));
         code = 16'($urandom());
         case ($urandom_range(0, 7))
            0: code = 16'h8000;
            1: code = 16'h7FFF;
            default: ;
         endcase
         run_conversion(2'($urandom_range(0, 3)), code,
                        ($urandom_range(0, 3) == 0) ? 30 : 0);
      end
   endtask

   task automatic test_steady_tail();
      drain();
      idle_on = 1'b0;
      set_config(32'h13, 32'h9, 32'h81, 2);
      send_noise(24);
   endtask

   initial begin
      bus_cfg.device_address  = DEVICE_ADDRESS_RST;
      bus_cfg.gain_mode_bits  = GAIN_MODE_BITS_RST;
      bus_cfg.config_low_byte = CONFIG_LOW_BYTE_RST;
      bus_cfg.settle_ticks    = SETTLE_TICKS_RST;
      bus_stage       = ST_IDLE;
      bus_quarter     = '0;
      bit_pos         = '0;
      byte_pos        = '0;
      rx_shift        = '0;
      rx_high         = '0;
      settle_count    = '0;
      latched_channel = '0;
      magnitude_hold  = '0;
      ack_missing     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_missing_ack();
      test_random_traffic();
      test_steady_tail();
      drain();
      repeat (4) @(posedge clock);
      if (bus_outputs_due.size() != 0)
         report_mismatch("transfers left over", bus_outputs_due.size(), 0);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
